### rtl/core/gwlg_pkg.sv
// ----------------------------------------------------------------------------
// gwlg_pkg
// Shared types and the linearization table builder for the gray converter.
// ----------------------------------------------------------------------------
package gwlg_pkg;

    // slot width of one table entry, enough for 2^LINEAR_BITS at the widest setting
    localparam int unsigned LIN_W = 25;
    localparam int unsigned LIN_N = 256;

    typedef logic [LIN_N*LIN_W-1:0] t_lin_tab;

    // sideband that travels with a request through the pipeline
    typedef struct packed {
        logic       valid;
        logic [7:0] alpha;
    } t_tag;

    // entry x is the largest v with v^5 * 255^12 <= x^12 * 2^(5*lb)
    function automatic t_lin_tab lin_table(input int unsigned lb);
        t_lin_tab           tab;
        logic [255:0]       den;
        logic [255:0]       num;
        logic [255:0]       t;
        logic [LIN_W-1:0]   v;
        logic [LIN_W-1:0]   cand;
        int                 x;
        int                 k;
        int                 bt;
        tab = '0;
        den = 256'd1;
        for (k = 0; k < 12; k++) begin
            den = den * 256'd255;
        end
        for (x = 0; x < LIN_N; x++) begin
            num = 256'd1;
            for (k = 0; k < 12; k++) begin
                num = num * 256'(x);
            end
            num = num << (5 * lb);
            v = '0;
            for (bt = int'(lb); bt >= 0; bt--) begin
                cand = v | (LIN_W'(1) << bt);
                t = den;
                for (k = 0; k < 5; k++) begin
                    t = t * 256'(cand);
                end
                if (t <= num) begin
                    v = cand;
                end
            end
            tab[x*LIN_W +: LIN_W] = v;
        end
        return tab;
    endfunction

endpackage

### rtl/core/gamma_weighted_luma_gray.sv
// ----------------------------------------------------------------------------
// gamma_weighted_luma_gray
// Gamma-corrected Rec.709 luma grayscale of packed ARGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_pixel_in and raise start; the request is taken at a clock edge
//   where start is high and busy is low. busy is low in every cycle after
//   reset, so one pixel can be issued each clock.
//   Each result appears on o_pixel_out for one cycle with o_done high,
//   in request order, after passing through every pipeline stage.
//   Pipeline: registered table lookup, weighting and summing, then 8 search
//   cells, one per gray bit, each looking up its candidate and comparing.
//   Throughput: one pixel per clock; every stage is a plain register step.
//   The receiver cannot stall: results are not held.
//   Reset (i_rst_n low, synchronous) drops all requests in flight and holds
//   busy high until the cycle after reset is released.
//   The linearization table is a constant built when the design elaborates.
// ----------------------------------------------------------------------------
module gamma_weighted_luma_gray #(
    parameter int unsigned LINEAR_BITS = 20,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_pixel_in,
    output logic        o_done,
    output logic [31:0] o_pixel_out
);

    localparam gwlg_pkg::t_lin_tab LIN_TAB = gwlg_pkg::lin_table(LINEAR_BITS);
    localparam int unsigned NCELL   = 8;
    localparam int unsigned LATENCY = 3 + NCELL;

    logic                   r_ready;
    logic                   take;
    gwlg_pkg::t_tag         tag  [0:NCELL];
    logic [LINEAR_BITS:0]   sum  [0:NCELL];
    logic [7:0]             gray [0:NCELL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy = ~r_ready;
    assign take = start & ~busy;

    gwlg_weigh #(
        .LINEAR_BITS (LINEAR_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .LIN_TAB     (LIN_TAB)
    ) u_weigh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_pixel (i_pixel_in),
        .o_tag   (tag[0]),
        .o_sum   (sum[0])
    );

    assign gray[0] = 8'd0;

    // cell k settles gray bit 7-k
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        gwlg_cell #(
            .LINEAR_BITS (LINEAR_BITS),
            .BIT         (NCELL - 1 - k),
            .LIN_TAB     (LIN_TAB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (tag[k]),
            .i_sum   (sum[k]),
            .i_gray  (gray[k]),
            .o_tag   (tag[k+1]),
            .o_sum   (sum[k+1]),
            .o_gray  (gray[k+1])
        );
    end

    assign o_done      = tag[NCELL].valid;
    assign o_pixel_out = {tag[NCELL].alpha, gray[NCELL], gray[NCELL], gray[NCELL]};

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##LATENCY o_done)
        else $error("request did not complete after the pipeline latency");

    a_alpha : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##LATENCY (o_pixel_out[31:24] == $past(i_pixel_in[31:24], LATENCY)))
        else $error("alpha lost its request on the way through");

    a_white : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (i_pixel_in[23:0] == 24'hFFFFFF)) |-> ##LATENCY (o_pixel_out[7:0] == 8'hFF))
        else $error("full white did not map to full gray");

endmodule

### rtl/core/gwlg_weigh.sv
// ----------------------------------------------------------------------------
// gwlg_weigh
// Linearizes red, green and blue and forms the weighted linear luma sum.
// ----------------------------------------------------------------------------
module gwlg_weigh #(
    parameter int unsigned      LINEAR_BITS = 20,
    parameter int unsigned      WEIGHT_BITS = 16,
    parameter gwlg_pkg::t_lin_tab LIN_TAB   = '0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [31:0]             i_pixel,
    output gwlg_pkg::t_tag          o_tag,
    output logic [LINEAR_BITS:0]    o_sum
);

    localparam int unsigned LW     = LINEAR_BITS + 1;
    localparam int unsigned PROD_W = LINEAR_BITS + 1 + WEIGHT_BITS;
    localparam int unsigned FULL   = 1 << WEIGHT_BITS;
    localparam int unsigned WR_INT = (2126 * FULL + 5000) / 10000;
    localparam int unsigned WB_INT = (722 * FULL + 5000) / 10000;
    localparam int unsigned WG_INT = FULL - WR_INT - WB_INT;
    localparam logic [WEIGHT_BITS-1:0] W_RED   = WEIGHT_BITS'(WR_INT);
    localparam logic [WEIGHT_BITS-1:0] W_GREEN = WEIGHT_BITS'(WG_INT);
    localparam logic [WEIGHT_BITS-1:0] W_BLUE  = WEIGHT_BITS'(WB_INT);

    logic               r_vld1, r_vld2, r_vld3;
    logic [7:0]         r_alpha1, r_alpha2, r_alpha3;
    logic [LW-1:0]      r_lin_r, r_lin_g, r_lin_b;
    logic [PROD_W-1:0]  r_prod_r, r_prod_g, r_prod_b;
    logic [LW-1:0]      r_sum;
    logic [LW-1:0]      n_lin_r, n_lin_g, n_lin_b;
    logic [PROD_W-1:0]  n_prod_r, n_prod_g, n_prod_b;
    logic [PROD_W+1:0]  sum_full;
    logic [LW-1:0]      n_sum;

    always_comb begin
        n_lin_r = LIN_TAB[32'(i_pixel[23:16]) * gwlg_pkg::LIN_W +: LW];
        n_lin_g = LIN_TAB[32'(i_pixel[15:8])  * gwlg_pkg::LIN_W +: LW];
        n_lin_b = LIN_TAB[32'(i_pixel[7:0])   * gwlg_pkg::LIN_W +: LW];
    end

    always_comb begin
        n_prod_r = PROD_W'(r_lin_r) * PROD_W'(W_RED);
        n_prod_g = PROD_W'(r_lin_g) * PROD_W'(W_GREEN);
        n_prod_b = PROD_W'(r_lin_b) * PROD_W'(W_BLUE);
    end

    // weights sum to one, so the shifted sum never exceeds the top table entry
    always_comb begin
        sum_full = (PROD_W+2)'(r_prod_r) + (PROD_W+2)'(r_prod_g) + (PROD_W+2)'(r_prod_b);
        n_sum    = LW'(sum_full >> WEIGHT_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha1 <= i_pixel[31:24];
        r_lin_r  <= n_lin_r;
        r_lin_g  <= n_lin_g;
        r_lin_b  <= n_lin_b;
        r_alpha2 <= r_alpha1;
        r_prod_r <= n_prod_r;
        r_prod_g <= n_prod_g;
        r_prod_b <= n_prod_b;
        r_alpha3 <= r_alpha2;
        r_sum    <= n_sum;
    end

    assign o_tag = '{valid: r_vld3, alpha: r_alpha3};
    assign o_sum = r_sum;

endmodule

### rtl/core/gwlg_cell.sv
// ----------------------------------------------------------------------------
// gwlg_cell
// One step of the inverse search: decides a single bit of the gray value.
// ----------------------------------------------------------------------------
module gwlg_cell #(
    parameter int unsigned        LINEAR_BITS = 20,
    parameter int unsigned        BIT         = 7,
    parameter gwlg_pkg::t_lin_tab LIN_TAB     = '0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  gwlg_pkg::t_tag          i_tag,
    input  logic [LINEAR_BITS:0]    i_sum,
    input  logic [7:0]              i_gray,
    output gwlg_pkg::t_tag          o_tag,
    output logic [LINEAR_BITS:0]    o_sum,
    output logic [7:0]              o_gray
);

    localparam int unsigned LW = LINEAR_BITS + 1;

    logic           r_valid;
    logic [7:0]     r_alpha;
    logic [LW-1:0]  r_sum;
    logic [7:0]     r_gray;
    logic [7:0]     cand;
    logic [LW-1:0]  cand_lin;
    logic [7:0]     n_gray;

    // table is nondecreasing, so greedy bit setting finds the largest match
    always_comb begin
        cand     = i_gray | (8'(1) << BIT);
        cand_lin = LIN_TAB[32'(cand) * gwlg_pkg::LIN_W +: LW];
        n_gray   = (cand_lin <= i_sum) ? cand : i_gray;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha <= i_tag.alpha;
        r_sum   <= i_sum;
        r_gray  <= n_gray;
    end

    assign o_tag  = '{valid: r_valid, alpha: r_alpha};
    assign o_sum  = r_sum;
    assign o_gray = r_gray;

endmodule
